// ===== design/rmfh_pkg.sv =====
package rmfh_pkg;

    localparam int TASK_W   = 8;
    localparam int DEPTH_W  = 8;
    localparam int STATUS_W = 3;
    localparam int WAIT_W   = 4;

    localparam logic [DEPTH_W-1:0] DEPTH_MAX = 8'd255;

    typedef enum logic [1:0] {
        CMD_LOCK    = 2'd0,
        CMD_TRYLOCK = 2'd1,
        CMD_UNLOCK  = 2'd2,
        CMD_DESTROY = 2'd3
    } command_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_QUEUED    = 3'd1,
        ST_RELOCK    = 3'd2,
        ST_NOT_OWNER = 3'd3,
        ST_FULL      = 3'd4,
        ST_REFUSED   = 3'd5,
        ST_DEPTH     = 3'd6
    } status_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [TASK_W-1:0] task_id;
        logic              boot_context;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                woken_valid;
        logic [TASK_W-1:0]   woken_task;
        logic                is_locked;
        logic [TASK_W-1:0]   owner_task;
        logic [DEPTH_W-1:0]  depth_now;
        logic [WAIT_W-1:0]   waiting_now;
    } result_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_cmd_t;

endpackage

// ===== design/rmfh_ctrl.sv =====
module rmfh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                request_valid,
    output logic                request_stall,
    output logic                result_valid,
    input  logic                result_stall,
    output rmfh_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (request_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign request_stall = (state_reg != S_IDLE);
    assign result_valid  = (state_reg == S_OUT);
    assign cmd.capture   = (state_reg == S_IDLE) && request_valid;
    assign cmd.execute   = (state_reg == S_EXEC);

endmodule

// ===== design/rmfh_datapath.sv =====
module rmfh_datapath #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int TASK_ID_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic                cfg_data,
    input  rmfh_pkg::ctrl_cmd_t cmd,
    input  rmfh_pkg::request_t  request,
    output rmfh_pkg::result_t   result
);

    localparam int TID_W = (TASK_ID_BITS < rmfh_pkg::TASK_W) ? TASK_ID_BITS
                                                               : rmfh_pkg::TASK_W;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W:0]   PTR_WRAP = (PTR_W + 1)'(QUEUE_DEPTH);

    logic [TID_W-1:0] mem [QUEUE_DEPTH];
    logic [TID_W-1:0] head_data_reg;

    rmfh_pkg::request_t req_reg;
    rmfh_pkg::result_t  result_reg;

    logic                         recursive_enable_reg;
    logic                         held_reg,   held_next;
    logic [TID_W-1:0]             holder_reg, holder_next;
    logic [rmfh_pkg::DEPTH_W-1:0] depth_reg,  depth_next;
    logic [CNT_W-1:0]             count_reg,  count_next;
    logic [PTR_W-1:0]             head_reg,   head_next;

    logic [TID_W-1:0]    tid;
    logic                mine;
    logic [PTR_W:0]      tail_sum;
    logic [PTR_W-1:0]    tail;
    logic [PTR_W:0]      head_inc;
    logic                enqueue;
    logic                woken;
    rmfh_pkg::status_t   status;
    logic [TID_W+rmfh_pkg::TASK_W-1:0]  holder_ext;
    logic [TID_W+rmfh_pkg::TASK_W-1:0]  woken_ext;
    logic [CNT_W+rmfh_pkg::WAIT_W-1:0]  count_ext;

    assign tid  = req_reg.task_id[TID_W-1:0];
    assign mine = held_reg && (holder_reg == tid);

    assign tail_sum = {1'b0, head_reg} + (PTR_W + 1)'(count_reg);
    assign tail     = (tail_sum >= PTR_WRAP) ? PTR_W'(tail_sum - PTR_WRAP)
                                             : tail_sum[PTR_W-1:0];
    assign head_inc = {1'b0, head_reg} + (PTR_W + 1)'(1);

    always_comb
    begin
        held_next   = held_reg;
        holder_next = holder_reg;
        depth_next  = depth_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        enqueue     = 1'b0;
        woken       = 1'b0;
        status      = rmfh_pkg::ST_OK;
        case (req_reg.command)
            rmfh_pkg::CMD_DESTROY:
            begin
                held_next   = 1'b0;
                holder_next = '0;
                depth_next  = '0;
                count_next  = '0;
                head_next   = '0;
            end
            rmfh_pkg::CMD_LOCK:
            begin
                if (req_reg.boot_context)
                begin
                    held_next   = 1'b1;
                    holder_next = '0;
                    depth_next  = rmfh_pkg::DEPTH_W'(1);
                end
                else if (mine)
                begin
                    if (!recursive_enable_reg)
                    begin
                        status = rmfh_pkg::ST_RELOCK;
                    end
                    else if (depth_reg >= rmfh_pkg::DEPTH_MAX)
                    begin
                        status = rmfh_pkg::ST_DEPTH;
                    end
                    else
                    begin
                        depth_next = depth_reg + rmfh_pkg::DEPTH_W'(1);
                    end
                end
                else if (!held_reg)
                begin
                    held_next   = 1'b1;
                    holder_next = tid;
                    depth_next  = rmfh_pkg::DEPTH_W'(1);
                end
                else if (count_reg >= CNT_FULL)
                begin
                    status = rmfh_pkg::ST_FULL;
                end
                else
                begin
                    enqueue    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                    status     = rmfh_pkg::ST_QUEUED;
                end
            end
            rmfh_pkg::CMD_TRYLOCK:
            begin
                if (req_reg.boot_context)
                begin
                    status = rmfh_pkg::ST_REFUSED;
                end
                else if (mine && recursive_enable_reg)
                begin
                    if (depth_reg >= rmfh_pkg::DEPTH_MAX)
                    begin
                        status = rmfh_pkg::ST_DEPTH;
                    end
                    else
                    begin
                        depth_next = depth_reg + rmfh_pkg::DEPTH_W'(1);
                    end
                end
                else if (!held_reg)
                begin
                    held_next   = 1'b1;
                    holder_next = tid;
                    depth_next  = rmfh_pkg::DEPTH_W'(1);
                end
                else
                begin
                    status = rmfh_pkg::ST_REFUSED;
                end
            end
            rmfh_pkg::CMD_UNLOCK:
            begin
                if (req_reg.boot_context)
                begin
                    held_next   = 1'b0;
                    holder_next = '0;
                    depth_next  = '0;
                end
                else if (!mine)
                begin
                    status = rmfh_pkg::ST_NOT_OWNER;
                end
                else if (depth_reg > rmfh_pkg::DEPTH_W'(1))
                begin
                    depth_next = depth_reg - rmfh_pkg::DEPTH_W'(1);
                end
                else if (count_reg != '0)
                begin
                    woken       = 1'b1;
                    held_next   = 1'b1;
                    holder_next = head_data_reg;
                    depth_next  = rmfh_pkg::DEPTH_W'(1);
                    count_next  = count_reg - CNT_W'(1);
                    head_next   = (head_inc >= PTR_WRAP) ? '0 : head_inc[PTR_W-1:0];
                end
                else
                begin
                    held_next   = 1'b0;
                    holder_next = '0;
                    depth_next  = '0;
                end
            end
            default:
            begin
                status = rmfh_pkg::ST_OK;
            end
        endcase
    end

    assign holder_ext = {{rmfh_pkg::TASK_W{1'b0}}, holder_next};
    assign woken_ext  = {{rmfh_pkg::TASK_W{1'b0}}, (woken ? head_data_reg : {TID_W{1'b0}})};
    assign count_ext  = {{rmfh_pkg::WAIT_W{1'b0}}, count_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recursive_enable_reg <= 1'b0;
            held_reg             <= 1'b0;
            holder_reg           <= '0;
            depth_reg            <= '0;
            count_reg            <= '0;
            head_reg             <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                recursive_enable_reg <= cfg_data;
            end
            if (cmd.execute)
            begin
                held_reg   <= held_next;
                holder_reg <= holder_next;
                depth_reg  <= depth_next;
                count_reg  <= count_next;
                head_reg   <= head_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
        if (cmd.execute)
        begin
            result_reg.status      <= status;
            result_reg.woken_valid <= woken;
            result_reg.woken_task  <= woken_ext[rmfh_pkg::TASK_W-1:0];
            result_reg.is_locked   <= held_next;
            result_reg.owner_task  <= holder_ext[rmfh_pkg::TASK_W-1:0];
            result_reg.depth_now   <= depth_next;
            result_reg.waiting_now <= count_ext[rmfh_pkg::WAIT_W-1:0];
        end
    end

    // hold the oldest waiter ready for the next request
    always_ff @(posedge clk)
    begin
        if (cmd.execute && enqueue)
        begin
            mem[tail] <= tid;
        end
        head_data_reg <= mem[head_reg];
    end

    assign result = result_reg;

endmodule

// ===== design/recursive_mutex_fifo_handoff.sv =====
// channel   | valid          | stall          | payload
// ----------+----------------+----------------+---------------------------
// request   | request_valid  | request_stall  | request (rmfh_pkg::request_t)
// result    | result_valid   | result_stall   | result  (rmfh_pkg::result_t)
// config    | cfg_write      | none           | cfg_data (recursive_enable)
//
// A request is accepted, executed, then its result is presented.
// The next request is taken the cycle after its result is delivered.
// The wait queue is a circular buffer read ahead through a
// registered port, which fixes the execute step after the accept step.
// rst_n clears the mutex state, queue pointers and recursive_enable.
// A stalled result holds its value and blocks new requests.
module recursive_mutex_fifo_handoff #(
    parameter int QUEUE_DEPTH  = 8,
    parameter int TASK_ID_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic               cfg_data,
    input  logic               request_valid,
    output logic               request_stall,
    input  rmfh_pkg::request_t request,
    output logic               result_valid,
    input  logic               result_stall,
    output rmfh_pkg::result_t  result
);

    rmfh_pkg::ctrl_cmd_t cmd;

    rmfh_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .request_valid (request_valid),
        .request_stall (request_stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .cmd           (cmd)
    );

    rmfh_datapath #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .TASK_ID_BITS (TASK_ID_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .request   (request),
        .result    (result)
    );

endmodule
